[design/kcb_pkg.sv]
// shared types, tables and transform functions for the kuznyechik cipher
package kcb_pkg;

    localparam int BLK_W = 128;
    localparam int KEY_WORDS = 4;
    localparam int NUM_RK = 10;
    localparam int NUM_RC = 32;

    typedef logic [BLK_W-1:0] blk_t;

    typedef struct packed {
        logic dec;
        blk_t blk;
    } item_t;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_CONST,
        KS_ROUND,
        KS_IDLE
    } ks_state_t;

    localparam logic [7:0] GF_POLY = 8'hc3;
    localparam logic [7:0] GF_TOP  = 8'h80;

    localparam logic [7:0] LIN_COEF [16] = '{
        8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
        8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
    };

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
        logic [7:0] acc;
        logic [7:0] a;
        acc = '0;
        a = a_in;
        for (int k = 0; k < 8; k++) begin
            if (b_in[k]) acc = acc ^ a;
            if ((a & GF_TOP) != 8'h00) a = (a << 1) ^ GF_POLY;
            else a = a << 1;
        end
        return acc;
    endfunction

    // exactly one entry matches, so the or of gated indexes is the inverse
    function automatic logic [7:0] sbox_inv(input logic [7:0] x);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            r = r | ((SBOX[i] == x) ? i[7:0] : 8'h00);
        end
        return r;
    endfunction

    function automatic blk_t sub_fwd(input blk_t v);
        blk_t r;
        for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX[v[8*i +: 8]];
        return r;
    endfunction

    function automatic blk_t sub_inv(input blk_t v);
        blk_t r;
        for (int i = 0; i < 16; i++) r[8*i +: 8] = sbox_inv(v[8*i +: 8]);
        return r;
    endfunction

    // sixteen lfsr steps, flattened by synthesis into one xor network
    function automatic blk_t lin_fwd(input blk_t v_in);
        blk_t v;
        logic [7:0] top;
        v = v_in;
        for (int n = 0; n < 16; n++) begin
            top = '0;
            for (int i = 0; i < 16; i++) top = top ^ gf_mul(v[8*i +: 8], LIN_COEF[i]);
            v = {top, v[BLK_W-1:8]};
        end
        return v;
    endfunction

    function automatic blk_t lin_inv(input blk_t v_in);
        blk_t v;
        logic [7:0] low;
        v = v_in;
        for (int n = 0; n < 16; n++) begin
            low = v[BLK_W-1 -: 8];
            v = {v[BLK_W-9:0], 8'h00};
            for (int i = 1; i < 16; i++) low = low ^ gf_mul(v[8*i +: 8], LIN_COEF[i]);
            v[7:0] = low;
        end
        return v;
    endfunction

endpackage

[design/kcb_in_if.sv]
// input channel: request type and one block
interface kcb_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] data_lo;
    logic [63:0] data_hi;

    modport source (output valid, output req_type, output data_lo, output data_hi,
                    input ready);
    modport sink (input valid, input req_type, input data_lo, input data_hi,
                  output ready);
endinterface

interface kcb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_lo;
    logic [63:0] out_hi;

    modport source (output valid, output out_lo, output out_hi, input ready);
    modport sink (input valid, input out_lo, input out_hi, output ready);
endinterface

[design/kcb_stage.sv]
// one registered cipher round stage, encrypt or decrypt per item
module kcb_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  kcb_pkg::item_t in_item,
    input  kcb_pkg::blk_t  rk_enc,
    input  kcb_pkg::blk_t  rk_dec,
    output logic          out_valid,
    output kcb_pkg::item_t out_item
);
    import kcb_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    always_comb
    begin
        item_next.dec = in_item.dec;
        if (in_item.dec) item_next.blk = sub_inv(lin_inv(in_item.blk)) ^ rk_dec;
        else item_next.blk = lin_fwd(sub_fwd(in_item.blk)) ^ rk_enc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (en) valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid) item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

[design/kuznyechik_block_cipher.sv]
// one block per cycle sustained while the pipeline does not hold and the key schedule is idle
// ten register stages: input key xor, then one full round per stage
// the whole pipeline holds while the result register is full and not taken
// reset and every write to a key word (index below KEY_WORDS) run the key schedule on one round unit
// (load, then constant and feistel step 32 times); that write restarts it; no block is taken meanwhile
module kuznyechik_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [63:0] wr_data,
    kcb_in_if.sink      req,
    kcb_out_if.source   rsp
);
    import kcb_pkg::*;

    localparam int STAGES = NUM_RK - 1;

    // key schedule
    logic [63:0] kw_reg [KEY_WORDS];
    blk_t        rk_reg [NUM_RK];
    blk_t        a_reg, b_reg, c_reg;
    logic [4:0]  j_reg;
    ks_state_t   ks_reg, ks_next;
    blk_t        t_val;
    logic        kw_hit;

    assign kw_hit = wr_en && (wr_index < 8'(KEY_WORDS));
    assign t_val  = lin_fwd(sub_fwd(a_reg ^ c_reg)) ^ b_reg;

    always_comb
    begin
        ks_next = ks_reg;
        case (ks_reg)
            KS_LOAD:  ks_next = KS_CONST;
            KS_CONST: ks_next = KS_ROUND;
            KS_ROUND: ks_next = (j_reg == 5'(NUM_RC - 1)) ? KS_IDLE : KS_CONST;
            KS_IDLE:  ks_next = KS_IDLE;
            default:  ks_next = KS_IDLE;
        endcase
        // a new key word starts the schedule over from the words as they now stand
        if (kw_hit) ks_next = KS_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg <= KS_LOAD;
            for (int i = 0; i < KEY_WORDS; i++) kw_reg[i] <= '0;
        end
        else
        begin
            ks_reg <= ks_next;
            if (kw_hit) kw_reg[wr_index[1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ks_reg)
            KS_LOAD:
            begin
                a_reg <= {kw_reg[3], kw_reg[2]};
                b_reg <= {kw_reg[1], kw_reg[0]};
                rk_reg[0] <= {kw_reg[3], kw_reg[2]};
                rk_reg[1] <= {kw_reg[1], kw_reg[0]};
                j_reg <= '0;
            end
            KS_CONST: c_reg <= lin_fwd({{(BLK_W-5){1'b0}}, j_reg} + blk_t'(1));
            KS_ROUND:
            begin
                a_reg <= t_val;
                b_reg <= a_reg;
                j_reg <= j_reg + 5'd1;
                if (j_reg[2:0] == 3'd7)
                begin
                    rk_reg[{j_reg[4:3], 1'b0} + 4'd2] <= t_val;
                    rk_reg[{j_reg[4:3], 1'b0} + 4'd3] <= a_reg;
                end
            end
            KS_IDLE: ;
            default: ;
        endcase
    end

    // cipher pipeline
    logic  en;
    logic  v0_reg;
    item_t it0_reg;
    logic  sv [STAGES+1];
    item_t si [STAGES+1];

    assign en = !sv[STAGES] || rsp.ready;
    assign req.ready = en && (ks_reg == KS_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v0_reg <= 1'b0;
        else if (en) v0_reg <= req.valid && req.ready;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            it0_reg.dec <= req.req_type;
            it0_reg.blk <= {req.data_hi, req.data_lo}
                         ^ (req.req_type ? rk_reg[NUM_RK-1] : rk_reg[0]);
        end
    end

    assign sv[0] = v0_reg;
    assign si[0] = it0_reg;

    for (genvar s = 1; s <= STAGES; s++)
    begin : g_round
        kcb_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sv[s-1]),
            .in_item   (si[s-1]),
            .rk_enc    (rk_reg[s]),
            .rk_dec    (rk_reg[NUM_RK-1-s]),
            .out_valid (sv[s]),
            .out_item  (si[s])
        );
    end

    assign rsp.valid  = sv[STAGES];
    assign rsp.out_lo = si[STAGES].blk[63:0];
    assign rsp.out_hi = si[STAGES].blk[127:64];
endmodule

[bench/kuznyechik_block_cipher_test.sv]
// self-checking bench for the kuznyechik block cipher: directed table, random blocks, key changes
module kuznyechik_block_cipher_test;
    import kcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1530;
    localparam int IDX_KEY0 = 0;
    localparam int IDX_KEY1 = 1;
    localparam int IDX_KEY2 = 2;
    localparam int IDX_KEY3 = 3;
    localparam int IDX_BAD = 4;
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef struct {
        logic        op;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        known;
        logic [63:0] want_lo;
        logic [63:0] want_hi;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [7:0]  wr_index = '0;
    logic [63:0] wr_data = '0;

    kcb_in_if  req ();
    kcb_out_if rsp ();

    kuznyechik_block_cipher u_dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .req(req.sink), .rsp(rsp.source)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [63:0] key_reg [4];
    blk_t        rkey [10];
    blk_t        rconst [32];
    logic [7:0]  inv_box [256];
    logic [127:0] pending_blocks [$];
    int errors = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_enc = 0;
    int n_dec = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    vec_t table_v [$];

    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = a[7] ? ((a << 1) ^ 8'hc3) : (a << 1);
        end
        return acc;
    endfunction

    function automatic blk_t mix_fwd(blk_t v);
        logic [7:0] t;
        for (int n = 0; n < 16; n++) begin
            t = 8'h00;
            for (int i = 0; i < 16; i++) t ^= field_mul(v[8*i +: 8], LIN_COEF[i]);
            v = {t, v[127:8]};
        end
        return v;
    endfunction

    function automatic blk_t mix_inv(blk_t v);
        logic [7:0] t;
        for (int n = 0; n < 16; n++) begin
            t = v[127:120];
            v = {v[119:0], 8'h00};
            for (int i = 1; i < 16; i++) t ^= field_mul(v[8*i +: 8], LIN_COEF[i]);
            v[7:0] = t;
        end
        return v;
    endfunction

    function automatic blk_t subst(blk_t v, bit inverse);
        for (int i = 0; i < 16; i++)
            v[8*i +: 8] = inverse ? inv_box[v[8*i +: 8]] : SBOX[v[8*i +: 8]];
        return v;
    endfunction

    task automatic expand_key();
        blk_t a, b, t;
        a = {key_reg[3], key_reg[2]};
        b = {key_reg[1], key_reg[0]};
        rkey[0] = a;
        rkey[1] = b;
        for (int j = 0; j < 32; j++) begin
            t = mix_fwd(subst(a ^ rconst[j], 0)) ^ b;
            b = a;
            a = t;
            if ((j & 7) == 7) begin
                rkey[2 + (j >> 3) * 2] = a;
                rkey[3 + (j >> 3) * 2] = b;
            end
        end
    endtask

    function automatic blk_t cipher_block(logic op, blk_t v);
        if (op == OP_ENC) begin
            for (int r = 0; r < 9; r++) v = mix_fwd(subst(v ^ rkey[r], 0));
            v ^= rkey[9];
        end else begin
            v ^= rkey[9];
            for (int r = 8; r >= 0; r--) v = subst(mix_inv(v), 1) ^ rkey[r];
        end
        return v;
    endfunction

    int recv_mode = 0;
    int send_mode = 0;

    function automatic bit roll(int mode);
        if (mode == 1) return $urandom_range(99) < 49;
        if (mode == 2) return $urandom_range(99) < 33;
        return 0;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // response side: ready drawn every cycle, compare on handshake
    always @(posedge clk) begin
        logic [127:0] want;
        if (!rst_n) rsp.ready <= 1'b0;
        else begin
            if (rsp.valid && rsp.ready) begin
                n_recv++;
                if (pending_blocks.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h_%h", rsp.out_hi, rsp.out_lo);
                end else begin
                    want = pending_blocks.pop_front();
                    if (rsp.out_lo !== want[63:0] || rsp.out_hi !== want[127:64]) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at result %0d: expected %h_%h got %h_%h",
                                     n_recv, want[127:64], want[63:0], rsp.out_hi, rsp.out_lo);
                    end
                end
            end
            rsp.ready <= !roll(recv_mode);
        end
    end

    task automatic key_write(int idx, logic [63:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx[7:0];
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx <= IDX_KEY3) begin
            key_reg[idx] = val;
            expand_key();
        end
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // holds valid until the transaction is taken; caller keeps valid high back to back
    task automatic send_block(logic op, logic [63:0] lo, logic [63:0] hi, logic known,
                              logic [63:0] wlo, logic [63:0] whi);
        blk_t res;
        while (roll(send_mode)) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= op;
        req.data_lo <= lo;
        req.data_hi <= hi;
        do @(posedge clk); while (!req.ready);
        res = known ? {whi, wlo} : cipher_block(op, {hi, lo});
        pending_blocks.push_back(res);
        n_sent++;
        if (op == OP_ENC) n_enc++; else n_dec++;
    endtask

    task automatic idle_sender();
        req.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            default: return rnd64();
        endcase
    endfunction

    initial begin
        blk_t ct;
        logic [63:0] lo, hi;
        req.valid = 1'b0;
        req.req_type = 1'b0;
        req.data_lo = '0;
        req.data_hi = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < 256; i++) inv_box[SBOX[i]] = i[7:0];
        for (int i = 0; i < 32; i++) rconst[i] = mix_fwd(blk_t'(i + 1));
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        expand_key();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows under the all-zero key after reset; expected results come from cipher_block
        table_v.push_back('{OP_ENC, '0, '0, 0, '0, '0});
        table_v.push_back('{OP_ENC, '1, '1, 0, '0, '0});
        table_v.push_back('{OP_DEC, '0, '0, 0, '0, '0});
        table_v.push_back('{OP_DEC, '1, '1, 0, '0, '0});
        table_v.push_back('{OP_ENC, 64'h1, '0, 0, '0, '0});
        table_v.push_back('{OP_DEC, '0, 64'h8000000000000000, 0, '0, '0});
        foreach (table_v[i])
            send_block(table_v[i].op, table_v[i].lo, table_v[i].hi, table_v[i].known,
                       table_v[i].want_lo, table_v[i].want_hi);
        idle_sender();
        drain();

        // standard key and plaintext, block read as hi:lo = a15..a0
        key_write(IDX_KEY0, 64'h0123456789abcdef);
        key_write(IDX_KEY1, 64'hfedcba9876543210);
        key_write(IDX_KEY2, 64'h0011223344556677);
        key_write(IDX_KEY3, 64'h8899aabbccddeeff);
        key_write(IDX_BAD, 64'hdeadbeefdeadbeef);
        table_v.delete();
        table_v.push_back('{OP_ENC, 64'hffeeddccbbaa9988, 64'h1122334455667700, 1,
                            64'h5a468d42b9d4edcd, 64'h7f679d90bebc2430});
        table_v.push_back('{OP_DEC, 64'h5a468d42b9d4edcd, 64'h7f679d90bebc2430, 1,
                            64'hffeeddccbbaa9988, 64'h1122334455667700});
        table_v.push_back('{OP_ENC, '0, '1, 0, '0, '0});
        table_v.push_back('{OP_DEC, '1, '0, 0, '0, '0});
        foreach (table_v[i])
            send_block(table_v[i].op, table_v[i].lo, table_v[i].hi, table_v[i].known,
                       table_v[i].want_lo, table_v[i].want_hi);
        idle_sender();
        drain();

        // all-ones key extreme
        for (int i = 0; i < 4; i++) key_write(i, '1);
        send_block(OP_ENC, '0, '0, 0, '0, '0);
        send_block(OP_DEC, '1, '1, 0, '0, '0);
        idle_sender();
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 128 == 0) begin
                idle_sender();
                drain();
                send_mode = (n / 128) % 4 == 1 || (n / 128) % 4 == 3 ? ((n/128)%4 == 3 ? 2 : 1) : 0;
                recv_mode = (n / 128) % 4 == 2 ? 1 : ((n / 128) % 4 == 3 ? 2 : 0);
                key_write($urandom_range(3), pick64());
                if ($urandom_range(3) == 0) key_write($urandom_range(255, 4), rnd64());
            end
            lo = pick64();
            hi = pick64();
            // pair plaintexts with their ciphertext to close the round trip
            if ($urandom_range(3) == 0) begin
                ct = cipher_block(OP_ENC, {hi, lo});
                send_block(OP_DEC, ct[63:0], ct[127:64], 0, '0, '0);
            end else
                send_block(logic'($urandom_range(1)), lo, hi, 0, '0, '0);
        end
        idle_sender();
        drain();

        $display("%0d blocks sent (%0d encrypt, %0d decrypt), %0d results checked",
                 n_sent, n_enc, n_dec, n_recv);
        $display("keys: reset zero, standard vector, all ones, random words, ignored indexes");
        if (errors == 0 && pending_blocks.size() == 0)
            $display("TEST PASSED");
        else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
